// File: rtl/pl_pkg.sv
// Package for the positional list table: sizes, action and status codes,
// and the control word that the top level broadcasts to the row of cells.
// Depends on nothing.
`default_nettype none

package pl_pkg;

    localparam int CAPACITY  = 16;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int POS_W     = 7;
    localparam int POS_CMP_W = POS_W + 1;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_DELETE  = 2'd1,
        ACT_SEARCH  = 2'd2,
        ACT_DISPLAY = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        ST_INSERTED  = 4'd0,
        ST_BAD_INS   = 4'd1,
        ST_FULL      = 4'd2,
        ST_DELETED   = 4'd3,
        ST_BAD_DEL   = 4'd4,
        ST_FOUND     = 4'd5,
        ST_NOT_FOUND = 4'd6,
        ST_ELEMENT   = 4'd7,
        ST_EMPTY     = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         pos_idx;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: rtl/pl_if.sv
// Valid/ready channel interfaces for the positional list table.
// Depends on pl_pkg for the payload types.
`default_nettype none

interface pl_in_if import pl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface pl_out_if import pl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [3:0]               status;
    logic signed [DATA_W-1:0] value_res;
    logic                     last;

    modport source (output valid, output status, output value_res, output last, input ready);
    modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/positional_list_table.sv
// Positional list table: an ordered list held in a row of cells.
// Insert, delete, search and an empty display give one result beat in the next cycle;
// a display of count entries first enters the display state, then gives one beat per cycle
// while unstalled. Throughput: one single-result item per cycle, unstalled;
// the input is ready only while idle and the result register is empty or being taken.
// Synchronous active-low reset empties the list and drops any pending result beat.
`default_nettype none

module positional_list_table import pl_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    pl_in_if.sink      i_in,
    pl_out_if.source   o_out
);

    typedef enum logic [1:0] {
        S_IDLE    = 2'b01,
        S_DISPLAY = 2'b10
    } t_state;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [CNT_W-1:0]         r_left, n_left;
    logic                     r_ovalid, n_ovalid;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_last, n_last;

    t_cell_ctrl               w_ctrl;
    logic signed [DATA_W-1:0] w_val [CAPACITY];
    logic [CAPACITY-1:0]      w_hit;
    logic                     w_free;
    logic                     w_acc;
    logic                     w_emit;
    logic [POS_CMP_W-1:0]     w_pos;
    logic [POS_CMP_W-1:0]     w_cnt;
    logic                     w_ins_ok;
    logic                     w_del_ok;
    logic                     w_full;
    logic [IDX_W-1:0]         w_pos_idx;
    t_action                  w_act;

    assign w_free    = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && w_free;
    assign w_acc     = i_in.valid && i_in.ready;
    assign w_emit    = (r_state == S_DISPLAY) && w_free;
    assign w_act     = t_action'(i_in.action);
    assign w_pos     = POS_CMP_W'(i_in.position);
    assign w_cnt     = POS_CMP_W'(r_count);
    assign w_full    = (r_count == CNT_W'(CAPACITY));
    assign w_ins_ok  = (w_pos != '0) && (w_pos <= w_cnt + POS_CMP_W'(1)) && !w_full;
    assign w_del_ok  = (w_pos != '0) && (w_pos <= w_cnt);
    assign w_pos_idx = IDX_W'(i_in.position - POS_W'(1));

    always_comb begin
        w_ctrl.op      = OP_HOLD;
        w_ctrl.pos_idx = w_pos_idx;
        w_ctrl.count   = r_count;
        w_ctrl.data    = i_in.value;
        if (w_acc && (w_act == ACT_INSERT) && w_ins_ok) begin
            w_ctrl.op = OP_INSERT;
        end else if (w_acc && (w_act == ACT_DELETE) && w_del_ok) begin
            w_ctrl.op = OP_DELETE;
        end else if (w_emit) begin
            w_ctrl.op = OP_ROTATE;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_prev;
        logic signed [DATA_W-1:0] w_next;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_val[g+1];
        end
        pl_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (IDX_W'(g)),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_head  (w_val[0]),
            .o_value (w_val[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_ovalid = r_ovalid && !o_out.ready;
        n_status = r_status;
        n_value  = r_value;
        n_last   = r_last;
        if (w_acc) begin
            n_ovalid = 1'b1;
            n_last   = 1'b1;
            n_value  = '0;
            case (w_act)
                ACT_INSERT: begin
                    if (w_pos == '0 || w_pos > w_cnt + POS_CMP_W'(1)) begin
                        n_status = ST_BAD_INS;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_INSERTED;
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                ACT_DELETE: begin
                    if (w_del_ok) begin
                        n_status = ST_DELETED;
                        n_value  = w_val[w_pos_idx];
                        n_count  = r_count - CNT_W'(1);
                    end else begin
                        n_status = ST_BAD_DEL;
                    end
                end
                ACT_SEARCH: begin
                    n_status = (|w_hit) ? ST_FOUND : ST_NOT_FOUND;
                    n_value  = i_in.value;
                end
                ACT_DISPLAY: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_ovalid = r_ovalid && !o_out.ready;
                        n_state  = S_DISPLAY;
                        n_left   = r_count;
                    end
                end
                default: begin
                    n_status = ST_EMPTY;
                end
            endcase
        end else if (w_emit) begin
            n_ovalid = 1'b1;
            n_status = ST_ELEMENT;
            n_value  = w_val[0];
            n_last   = (r_left == CNT_W'(1));
            n_left   = r_left - CNT_W'(1);
            if (r_left == CNT_W'(1)) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_value  <= n_value;
        r_last   <= n_last;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.status    = r_status;
    assign o_out.value_res = r_value;
    assign o_out.last      = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list occupancy above capacity");

    a_display_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DISPLAY) |-> (r_left != '0) && (r_left <= r_count))
        else $error("display counter out of range");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_act == ACT_INSERT) && w_ins_ok)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_display_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_left == CNT_W'(1))) |=> (r_state == S_IDLE) && r_ovalid && r_last)
        else $error("final display beat did not end the item");
`endif

endmodule

`default_nettype wire

// File: rtl/pl_cell.sv
// One cell of the list: holds one entry, shifts toward or away from its
// neighbors, and compares its entry with the search key. Depends on pl_pkg.
`default_nettype none

module pl_cell import pl_pkg::*; (
    input  wire                      i_clk,
    input  wire  [IDX_W-1:0]         i_idx,
    input  t_cell_ctrl               i_ctrl,
    input  wire  signed [DATA_W-1:0] i_prev,
    input  wire  signed [DATA_W-1:0] i_next,
    input  wire  signed [DATA_W-1:0] i_head,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_hit
);

    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic [CNT_W-1:0]         w_idx_ext;

    assign w_idx_ext = CNT_W'(i_idx);

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (i_idx == i_ctrl.pos_idx) begin
                    n_value = i_ctrl.data;
                end else if (i_idx > i_ctrl.pos_idx) begin
                    n_value = i_prev;
                end
            end
            OP_DELETE: begin
                if (i_idx >= i_ctrl.pos_idx) begin
                    n_value = i_next;
                end
            end
            OP_ROTATE: begin
                if (w_idx_ext + CNT_W'(1) == i_ctrl.count) begin
                    n_value = i_head;
                end else begin
                    n_value = i_next;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_hit   = (w_idx_ext < i_ctrl.count) && (r_value == i_ctrl.data);

endmodule

`default_nettype wire
